FILE: sv/sem_pkg.sv
// Shared types, constants and helper functions of the Sobel edge magnitude unit.
`timescale 1ns / 1ps
package sem_pkg;

  // Line store depth and the width of a column index.
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);

  // Widths fixed by the register and field definitions.
  localparam int WCFG_W = 11;
  localparam int HCFG_W = 13;
  localparam int ROW_W = 13;
  localparam int CNT_W = 23;
  localparam int PIX_W = 8;
  localparam int MAG_W = 8;

  // Reset values of the geometry registers.
  localparam logic [WCFG_W-1:0] WIDTH_RESET = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);
  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(640 * 480);

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Item opcodes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic opcode;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic last;
  } out_item_t;

  // Frame geometry that the front part works from.
  typedef struct packed {
    logic [WCFG_W-1:0] eff_width;
    logic [CNT_W-1:0] total;
  } geom_t;

  // A classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] value;
    logic top_ok;
    logic mid_ok;
    logic produce;
    logic last;
    logic zero_left;
    logic zero_right;
  } work_t;

  // Status of the back part's result register.
  typedef struct packed {
    logic load;
    logic occupied;
  } back_status_t;

  function automatic logic [WCFG_W-1:0] clamp_width(input logic [WCFG_W-1:0] w);
    logic [WCFG_W-1:0] r;
    r = w;
    if (w < WCFG_W'(3)) begin
      r = WCFG_W'(3);
    end else if (int'(w) > MAX_WIDTH) begin
      r = WCFG_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  function automatic logic [HCFG_W-1:0] clamp_height(input logic [HCFG_W-1:0] h);
    logic [HCFG_W-1:0] r;
    r = h;
    if (h < HCFG_W'(3)) begin
      r = HCFG_W'(3);
    end else if (int'(h) > MAX_HEIGHT) begin
      r = HCFG_W'(MAX_HEIGHT);
    end
    return r;
  endfunction

endpackage

FILE: sv/sem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sem_queue.sv
// Short FIFO of classified items between the front and back parts.
`timescale 1ns / 1ps
module sem_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sem_pkg::work_t din,
  output logic           full,
  input  logic           pop,
  output sem_pkg::work_t dout,
  output logic           empty,
  output logic [sem_pkg::QCNT_W-1:0] count
);
  import sem_pkg::*;

  work_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count_next;
  logic do_push;
  logic do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

FILE: sv/sem_front.sv
// Front part: raster position tracking and classification of each accepted item.
`timescale 1ns / 1ps
module sem_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  sem_pkg::geom_t    geom,
  input  logic              accept,
  input  sem_pkg::in_item_t item,
  output sem_pkg::work_t    work
);
  import sem_pkg::*;

  logic [CNT_W-1:0] k;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] last_k;
  logic [WCFG_W-1:0] col_inc;
  logic in_image;

  assign last_k = geom.total + CNT_W'(geom.eff_width);
  assign in_image = (k < geom.total);
  assign col_inc = WCFG_W'(col) + 1'b1;

  always_comb begin
    work.col = col;
    work.value = (item.opcode == OP_PIXEL && in_image) ? item.pixel : '0;
    work.top_ok = (row >= ROW_W'(2));
    work.mid_ok = (row >= ROW_W'(1));
    work.produce = (k > CNT_W'(geom.eff_width)) && (k <= last_k);
    work.last = (k == last_k);
    work.zero_left = (col == COL_W'(1));
    work.zero_right = (col == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      k <= '0;
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (work.last) begin
        k <= '0;
        col <= '0;
        row <= '0;
      end else begin
        k <= k + 1'b1;
        if (col_inc >= geom.eff_width) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= COL_W'(col_inc);
        end
      end
    end
  end

endmodule

FILE: sv/sem_back.sv
// Back part: line stores, 3x3 window, Sobel sums, iterative square root, result register.
`timescale 1ns / 1ps
module sem_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic                   q_empty,
  input  sem_pkg::work_t         q_item,
  output logic                   q_pop,
  output logic                   res_valid,
  output sem_pkg::out_item_t     res,
  input  logic                   res_pop,
  output sem_pkg::back_status_t  status
);
  import sem_pkg::*;

  localparam int LS_W = 2 * PIX_W;
  localparam int SUM_W = PIX_W + 2;
  localparam int GRAD_W = SUM_W + 1;
  localparam int SQ_W = 2 * GRAD_W;
  localparam int S_W = 21;
  localparam logic [S_W-1:0] SAT_LIMIT = S_W'(255 * 255);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_SQUARE,
    S_ROOT,
    S_OUT
  } state_t;

  state_t state;
  work_t cur;
  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] win_next [3][3];
  logic [PIX_W-1:0] cv [3][3];
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [GRAD_W-1:0] gx_next;
  logic signed [GRAD_W-1:0] gy_next;
  logic signed [SQ_W-1:0] sqx;
  logic signed [SQ_W-1:0] sqy;
  logic [S_W-1:0] s_sum;
  logic [S_W-1:0] s;
  logic sat;
  logic [MAG_W-1:0] root;
  logic [2:0] step;
  logic [MAG_W-1:0] trial;
  logic [2*MAG_W-1:0] trial_sq;
  logic [SUM_W-1:0] right_sum;
  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] bottom_sum;
  logic [SUM_W-1:0] top_sum;
  logic [PIX_W-1:0] top_px;
  logic [PIX_W-1:0] mid_px;
  logic [LS_W-1:0] ls_rdata;
  logic [LS_W-1:0] ls_wdata;
  logic [COL_W-1:0] ls_raddr;
  logic ls_we;
  logic load;

  // Upper row in the high byte, middle row in the low byte.
  sem_ram #(
    .WIDTH(LS_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (cur.col),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign ls_raddr = q_item.col;
  assign ls_we = (state == S_DATA);
  assign ls_wdata = {ls_rdata[PIX_W-1:0], cur.value};
  assign top_px = cur.top_ok ? ls_rdata[LS_W-1:PIX_W] : '0;
  assign mid_px = cur.mid_ok ? ls_rdata[PIX_W-1:0] : '0;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[0][r] = win[1][r];
      win_next[1][r] = win[2][r];
    end
    win_next[2][0] = top_px;
    win_next[2][1] = mid_px;
    win_next[2][2] = cur.value;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        cv[c][r] = win_next[c][r];
      end
    end
    if (cur.zero_left) begin
      for (int r = 0; r < 3; r++) begin
        cv[0][r] = '0;
      end
    end
    if (cur.zero_right) begin
      for (int r = 0; r < 3; r++) begin
        cv[2][r] = '0;
      end
    end
  end

  assign right_sum = SUM_W'(cv[2][0]) + {1'b0, cv[2][1], 1'b0} + SUM_W'(cv[2][2]);
  assign left_sum = SUM_W'(cv[0][0]) + {1'b0, cv[0][1], 1'b0} + SUM_W'(cv[0][2]);
  assign bottom_sum = SUM_W'(cv[0][2]) + {1'b0, cv[1][2], 1'b0} + SUM_W'(cv[2][2]);
  assign top_sum = SUM_W'(cv[0][0]) + {1'b0, cv[1][0], 1'b0} + SUM_W'(cv[2][0]);
  assign gx_next = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
  assign gy_next = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});

  assign sqx = gx * gx;
  assign sqy = gy * gy;
  assign s_sum = S_W'(sqx) + S_W'(sqy);

  assign trial = root | (MAG_W'(1) << step);
  assign trial_sq = trial * trial;

  assign load = (state == S_OUT) && (!res_valid || res_pop);
  assign status.load = load;
  assign status.occupied = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        res.magnitude <= root;
        res.last <= cur.last;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end

      if (restart) begin
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            win[c][r] <= '0;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_item;
            state <= S_DATA;
          end
        end
        S_DATA: begin
          // The window restarts right after the item that ends the frame.
          for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
              win[c][r] <= cur.last ? '0 : win_next[c][r];
            end
          end
          gx <= gx_next;
          gy <= gy_next;
          state <= cur.produce ? S_SQUARE : S_IDLE;
        end
        S_SQUARE: begin
          s <= s_sum;
          sat <= (s_sum >= SAT_LIMIT);
          root <= '0;
          step <= 3'(MAG_W - 1);
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sat) begin
            root <= '1;
            state <= S_OUT;
          end else begin
            if (S_W'(trial_sq) <= s) begin
              root <= trial;
            end
            if (step == '0) begin
              state <= S_OUT;
            end else begin
              step <= step - 1'b1;
            end
          end
        end
        S_OUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sobel_edge_magnitude_unit.sv
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
`timescale 1ns / 1ps
//
//  Channel    Direction  Handshake                    Payload
//  ---------  ---------  ---------------------------  -------------------------------
//  item       in         push / full                  opcode (1), pixel (8)
//  result     out        pop / empty                  magnitude (8), last (1)
//  config     in         psel, penable, pwrite, pready paddr (3), pwdata/prdata (32)
//
// In the back part an item with no result passes the idle and data states; an item
// with a result goes on through the square, root and output states; its 8-step
// bit-serial root, skipped on saturation, follows line store read and Sobel sums.
// Reset is synchronous and active high: geometry returns to 640 x 480, the frame
// position and the window clear, and the queues empty. Line stores are not cleared.
// The front accepts items while the two-entry work queue has room, and the back part
// keeps working while a finished result waits in its output register.
//
module sobel_edge_magnitude_unit (
  input  logic               clk,
  input  logic               rst,
  // Item channel.
  input  logic               push,
  output logic               full,
  input  sem_pkg::in_item_t  item,
  // Result channel.
  output logic               empty,
  input  logic               pop,
  output sem_pkg::out_item_t result,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sem_pkg::*;

  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  logic [WCFG_W-1:0] width_next;
  logic [HCFG_W-1:0] height_next;
  logic [CNT_W-1:0] total;
  logic [WCFG_W+HCFG_W-1:0] total_next;
  logic cfg_wr;
  logic reg_sel;
  geom_t geom;
  work_t work;
  work_t q_item;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic [QCNT_W-1:0] q_count;
  logic accept;
  logic res_valid;
  back_status_t bk_status;

  // Configuration registers. Every write restarts the frame, and the pixel count
  // of the frame is worked out from the new geometry in the same cycle.
  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_next = image_width;
    height_next = image_height;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH: width_next = pwdata[WCFG_W-1:0];
        REG_IMAGE_HEIGHT: height_next = pwdata[HCFG_W-1:0];
        default: width_next = image_width;
      endcase
    end
  end

  assign total_next = clamp_width(width_next) * clamp_height(height_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      total <= TOTAL_RESET;
    end else if (cfg_wr) begin
      image_width <= width_next;
      image_height <= height_next;
      total <= CNT_W'(total_next);
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH: prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default: prdata = '0;
    endcase
  end

  assign geom.eff_width = clamp_width(image_width);
  assign geom.total = total;

  // Front part: one item per cycle into the work queue while it has room.
  assign full = q_full;
  assign accept = push && !q_full;

  sem_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .geom    (geom),
    .accept  (accept),
    .item    (item),
    .work    (work)
  );

  sem_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (work),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty),
    .count (q_count)
  );

  // Back part: line stores, window, gradient and magnitude, result register.
  sem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (result),
    .res_pop   (pop),
    .status    (bk_status)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  // The work queue never holds more entries than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("work queue count exceeds its depth");

  // A new result only enters the output register when it is free or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    bk_status.load |-> (!bk_status.occupied || pop))
    else $error("result register overwritten before it was taken");

  // The back part pops the queue only when it holds an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("work queue popped while empty");

  // A result that was taken leaves the output register unless a new one replaces it.
  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !bk_status.load) |=> empty)
    else $error("result register stayed full after its item was taken");
`endif

endmodule

FILE: verif/sobel_edge_checker.sv
// Checker that predicts the unit's Sobel magnitudes and compares them with its results.
`timescale 1ns / 1ps
module sobel_edge_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  sem_pkg::in_item_t  item,
  input  logic               empty,
  input  logic               pop,
  input  sem_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 outstanding,
  output int                 errors
);
  import sem_pkg::*;

  logic [WCFG_W-1:0] width_reg;
  logic [HCFG_W-1:0] height_reg;
  logic [PIX_W-1:0]  upper_line [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]  win [3][3];  // [column left..right][row top..bottom]
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       position;
  out_item_t         expected_edges [$];
  out_item_t         want;
  logic [31:0]       reg_value;

  initial begin
    outstanding = 0;
    errors = 0;
  end

  function automatic int unsigned frame_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) begin
      w = 3;
    end else if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) begin
      h = 3;
    end else if (h > MAX_HEIGHT) begin
      h = MAX_HEIGHT;
    end
    return h;
  endfunction

  // Floor of the square root, saturated at the top of the magnitude range.
  function automatic logic [MAG_W-1:0] root_sat(input int s);
    int r;
    r = 0;
    if (s >= 255 * 255) begin
      return 8'd255;
    end
    while ((r + 1) * (r + 1) <= s) begin
      r++;
    end
    return MAG_W'(r);
  endfunction

  task automatic restart_frame();
    int c;
    int r;
    for (c = 0; c < 3; c++) begin
      for (r = 0; r < 3; r++) begin
        win[c][r] = '0;
      end
    end
    col_pos = 0;
    row_pos = 0;
    position = 0;
  endtask

  // Moves the raster position by one item and queues the magnitude it finishes.
  task automatic advance_raster(input in_item_t it);
    int unsigned     w;
    int unsigned     total;
    int unsigned     k;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    int              cw [3][3];
    int              gx;
    int              gy;
    int              c;
    int              r;
    out_item_t       res;
    w = frame_width();
    total = w * frame_height();
    k = position;
    v = '0;
    top = '0;
    mid = '0;
    if (it.opcode == OP_PIXEL && k < total) begin
      v = it.pixel;
    end
    if (row_pos >= 2) begin
      top = upper_line[col_pos];
    end
    if (row_pos >= 1) begin
      mid = middle_line[col_pos];
    end
    upper_line[col_pos] = middle_line[col_pos];
    middle_line[col_pos] = v;
    for (r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = v;
    if (k >= w + 1 && k < total + w + 1) begin
      for (c = 0; c < 3; c++) begin
        for (r = 0; r < 3; r++) begin
          cw[c][r] = win[c][r];
        end
      end
      // The window straddles a row boundary at the first and last columns.
      for (r = 0; r < 3; r++) begin
        if (col_pos == 1) begin
          cw[0][r] = 0;
        end
        if (col_pos == 0) begin
          cw[2][r] = 0;
        end
      end
      gx = (cw[2][0] + 2 * cw[2][1] + cw[2][2]) - (cw[0][0] + 2 * cw[0][1] + cw[0][2]);
      gy = (cw[0][2] + 2 * cw[1][2] + cw[2][2]) - (cw[0][0] + 2 * cw[1][0] + cw[2][0]);
      res.magnitude = root_sat(gx * gx + gy * gy);
      res.last = (k == total + w);
      expected_edges.push_back(res);
    end
    if (k == total + w) begin
      restart_frame();
    end else begin
      position = k + 1;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_frame();
      expected_edges.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IMAGE_WIDTH) begin
          width_reg = pwdata[WCFG_W-1:0];
        end else begin
          height_reg = pwdata[HCFG_W-1:0];
        end
        restart_frame();
      end
      if (psel && penable && !pwrite && pready) begin
        reg_value = (paddr[2] == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
        if (prdata !== reg_value) begin
          errors++;
          $display("%0t: register read at %0d: expected %0d actual %0d",
                   $time, paddr, reg_value, prdata);
        end
      end
      // Results are compared before this edge's item is predicted, so an early
      // result cannot match an expectation that did not exist yet.
      if (pop && !empty) begin
        if (expected_edges.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none actual magnitude %0d last %0d",
                   $time, result.magnitude, result.last);
        end else begin
          want = expected_edges.pop_front();
          if (result.magnitude !== want.magnitude) begin
            errors++;
            $display("%0t: magnitude mismatch: expected %0d actual %0d",
                     $time, want.magnitude, result.magnitude);
          end
          if (result.last !== want.last) begin
            errors++;
            $display("%0t: last flag mismatch: expected %0d actual %0d",
                     $time, want.last, result.last);
          end
        end
      end
      if (push && !full) begin
        advance_raster(item);
      end
    end
    outstanding <= expected_edges.size();
  end

endmodule

FILE: verif/sobel_edge_magnitude_unit_tb.sv
// Testbench top of the Sobel edge magnitude unit: stimulus, result sink and verdict.
`timescale 1ns / 1ps
module sobel_edge_magnitude_unit_tb;
  import sem_pkg::*;

  // Register addresses: one 32-bit register per word.
  localparam logic [2:0] WIDTH_ADDR = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [2:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

  // Cycles the unit may still spend on items without a result once the last
  // expected result has left.
  localparam int SETTLE_CYCLES = 30;
  // Length of the one long hold-off of the result side.
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 230;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  in_item_t    item = '0;
  logic        full;
  logic        empty;
  logic [31:0] prdata;
  logic        pready;
  out_item_t   result;
  int          outstanding;
  int          fail_count;

  // Sender pacing: items go out in bursts, with a random idle gap bounded by gap_max
  // between bursts; gap_max of zero means back-to-back items.
  int burst_left = 0;
  int gap_max = 0;
  int items_sent = 0;
  // Requests for a long hold-off, raised by the stimulus and served by the sink.
  int hold_requests = 0;
  int holds_done = 0;
  // Effective frame size as the stimulus sees it, used to shape frames.
  int frame_w = 640;
  int frame_h = 480;

  always #5 clk = ~clk;

  sobel_edge_magnitude_unit uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker sees every handshake and every register access, keeps its own
  // copy of the frame state and reports how many results are still owed.
  sobel_edge_checker edge_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .outstanding (outstanding),
    .errors      (fail_count)
  );

  // A hang anywhere ends the run here. The slowest correct run stays far below
  // this: about 600 items plus result stalls.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result sink. It stalls on a pattern of its own: windows of random length,
  // each with its own stall rate, from never stalling to stalling most cycles.
  // On request it holds off for a long hold-off of length LONG_HOLD so the unit backs up.
  initial begin : result_sink
    int stall_pct;
    int span;
    stall_pct = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (span == 0) begin
          span = $urandom_range(80, 10);
          case ($urandom_range(3, 0))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        span--;
        pop <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  function automatic int eff_size(input int raw, input int hi);
    if (raw < 3) begin
      return 3;
    end
    return (raw > hi) ? hi : raw;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      0: return PIX_W'($urandom_range(255, 0));
      1: return ($urandom_range(1, 0) == 1) ? 8'hFF : 8'h00;
      default: return PIX_W'($urandom_range(130, 120));
    endcase
  endfunction

  // Offers one item and returns at the edge that accepts it. push stays high
  // so the next item can follow without a bubble.
  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
    in_item_t next_item;
    if (gap_max > 0 && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      burst_left = $urandom_range(12, 1);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    next_item.opcode = op;
    next_item.pixel = pix;
    item <= next_item;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Stops the sender until every expected result has been taken, then lets
  // the back part finish items that carry no result.
  task automatic wait_idle(input int settle);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle until pready, then an idle cycle
  // so psel is never lowered and raised within one step.
  task automatic apb_transfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both geometry registers while the unit is idle and reads them back.
  task automatic set_geometry(input logic [31:0] w_data, input logic [31:0] h_data);
    wait_idle(SETTLE_CYCLES);
    apb_transfer(1'b1, WIDTH_ADDR, w_data);
    apb_transfer(1'b1, HEIGHT_ADDR, h_data);
    apb_transfer(1'b0, WIDTH_ADDR, '0);
    apb_transfer(1'b0, HEIGHT_ADDR, '0);
    frame_w = eff_size(int'(w_data[WCFG_W-1:0]), MAX_WIDTH);
    frame_h = eff_size(int'(h_data[HCFG_W-1:0]), MAX_HEIGHT);
  endtask

  // Sends count items from the start of a frame. Inside the image most items are
  // pixels and a few are drains; in the padding most are drains and a few are
  // pixels whose value the unit must ignore. At item pause_at the sender waits
  // until every result owed so far has come out.
  task automatic send_frame(input int count, input int noise_pct, input int style,
                            input int pause_at);
    int          i;
    int          area;
    logic        op;
    logic        noisy;
    area = frame_w * frame_h;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) begin
        wait_idle(0);
      end
      noisy = ($urandom_range(99, 0) < noise_pct);
      if (i < area) begin
        op = noisy ? OP_DRAIN : OP_PIXEL;
      end else begin
        op = noisy ? OP_PIXEL : OP_DRAIN;
      end
      send_item(op, pick_pixel(style));
    end
  endtask

  initial begin : stimulus
    int          start;
    int          round;
    int          frames;
    int          f;
    int          full_len;
    int          count;
    logic [31:0] w_data;
    logic [31:0] h_data;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry is 640 x 480; the first items of that frame owe no result
    // yet, so nothing may come out.
    gap_max = 6;
    send_frame(30, 5, 0, -1);

    // Directed part on the smallest image. The first frame has a checkerboard of
    // the pixel extremes with the center pixel sent as a drain, and pixels with
    // values mixed into the padding. The second frame, all white, follows without
    // a register write so the restart after the flagged result is exercised.
    // The result side holds off meanwhile, so the unit fills up and raises full.
    set_geometry(32'd3, 32'd3);
    gap_max = 0;
    hold_requests++;
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_PIXEL, 8'hAA);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_PIXEL, 8'h55);
    repeat (9) send_item(OP_PIXEL, 8'hFF);
    repeat (4) send_item(OP_DRAIN, 8'h00);

    // Width above the line store clamps to 1024, so the first items owe no result.
    gap_max = 3;
    set_geometry(32'd1025, 32'd0);
    send_frame(30, 3, 0, -1);
    // Height below 3 clamps to 3: a whole small frame, flagged result included.
    set_geometry(32'd5, 32'd0);
    send_frame(frame_w * frame_h + frame_w + 1, 3, 0, -1);

    // Both registers at their top legal values; only the first items are sent.
    set_geometry(32'd1024, 32'd4096);
    send_frame(30, 3, 1, -1);

    // Bits above each register's width are dropped; width 0 clamps to 3 and
    // height 4097 to 4096.
    set_geometry(32'hFFFF_F800, 32'd4097);
    send_frame(40, 10, 0, -1);
    set_geometry(32'd2, 32'hFFFF_E002);
    send_frame(frame_w * frame_h + frame_w + 1, 0, 1, -1);
    set_geometry(32'd2047, 32'd8191);
    send_frame(20, 10, 0, -1);

    // Random part: small images of random shape, one or two frames per setting,
    // the last one sometimes cut short by the next register write.
    start = items_sent;
    round = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      w_data = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
      h_data = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(6, 3);
      if ($urandom_range(3, 0) == 0) begin
        w_data = w_data | ($urandom() & 32'hFFFF_F800);
        h_data = h_data | ($urandom() & 32'hFFFF_E000);
      end
      if (round % 4 == 3) begin
        // A write to one register alone must also restart the frame.
        wait_idle(SETTLE_CYCLES);
        apb_transfer(1'b1, HEIGHT_ADDR, h_data);
        frame_h = eff_size(int'(h_data[HCFG_W-1:0]), MAX_HEIGHT);
      end else begin
        set_geometry(w_data, h_data);
      end
      gap_max = (round % 3 == 0) ? 0 : $urandom_range(8, 1);
      burst_left = 0;
      frames = $urandom_range(2, 1);
      full_len = frame_w * frame_h + frame_w + 1;
      for (f = 0; f < frames; f++) begin
        count = full_len;
        if (f == frames - 1 && $urandom_range(4, 0) == 0) begin
          count = $urandom_range(full_len - 1, 1);
        end
        send_frame(count, 8, $urandom_range(2, 0), (round == 1) ? count / 2 : -1);
      end
      round++;
    end

    // Everything owed must arrive, and nothing more may follow it.
    wait_idle(4 * SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sem_pkg.sv
sv/sem_ram.sv
sv/sem_queue.sv
sv/sem_front.sv
sv/sem_back.sv
sv/sobel_edge_magnitude_unit.sv
verif/sobel_edge_checker.sv
verif/sobel_edge_magnitude_unit_tb.sv
